// ----- design/cddo_pkg.sv -----
// ----------------------------------------------------------------------------
// cddo_pkg
// Shared types, constants and month-length helpers for the calendar date
// day offset block.
// ----------------------------------------------------------------------------
package cddo_pkg;

   // field widths
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int OFFS_W   = 13;
   localparam int STATUS_W = 2;

   // working widths: year walks a little past 1..9999, day spans the offset
   localparam int YWORK_W  = YEAR_W + 1;
   localparam int DWORK_W  = OFFS_W + 1;
   localparam int YMOD_W   = 9;

   localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
   localparam logic [YEAR_W-1:0]  CYCLE_LEN  = 14'd400;
   localparam logic [YMOD_W-1:0]  CYCLE_LAST = 9'd399;
   localparam logic [2:0]         REDUCE_TOP = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_DATE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_YEAR = 2'd2;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_REDUCE = 4'b0010,
      ST_CHECK  = 4'b0100,
      ST_WALK   = 4'b1000
   } state_type;

   // leap rule from the year taken modulo 400
   function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
      logic by_100;
      begin
         by_100 = (ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300);
         is_leap = (ymod[1:0] == 2'b00) && !by_100;
      end
   endfunction

   // days in a month, zero for a month code outside 1..12
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      begin
         case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                  month_len = 5'd30;
            4'd2:    month_len = leap ? 5'd29 : 5'd28;
            default: month_len = 5'd0;
         endcase
      end
   endfunction

endpackage

// ----- design/calendar_date_day_offset.sv -----
// ----------------------------------------------------------------------------
// calendar_date_day_offset
// Adds a signed day offset to a Gregorian date, one month per cycle.
// ----------------------------------------------------------------------------
// Usage: present a date and offset on the req_ ports and raise start while
// busy is low; the item is taken at that clock edge and busy rises on the
// next cycle. The block first reduces the year modulo 400 with six
// compare-and-subtract steps, checks the date, then walks the day count
// through month lengths, one month boundary per cycle, through a single
// shared day adder; an invalid date ends the item at the check. The result
// is on the rsp_ ports with rsp_done high for exactly one cycle, and busy
// falls in that same cycle, so the next item may be started then. Status 1
// flags an invalid date, status 2 a result year outside 1..9999; both echo
// the input date. The receiver cannot stall the result channel. A synchronous
// reset returns the sequencer to idle and drops rsp_done; no item is in
// flight afterwards.
// ----------------------------------------------------------------------------
module calendar_date_day_offset (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [cddo_pkg::YEAR_W-1:0]       req_in_year,
   input  logic [cddo_pkg::MONTH_W-1:0]      req_in_month,
   input  logic [cddo_pkg::DAY_W-1:0]        req_in_day,
   input  logic signed [cddo_pkg::OFFS_W-1:0] req_day_offset,
   output logic                              rsp_done,
   output logic [cddo_pkg::YEAR_W-1:0]       rsp_out_year,
   output logic [cddo_pkg::MONTH_W-1:0]      rsp_out_month,
   output logic [cddo_pkg::DAY_W-1:0]        rsp_out_day,
   output logic [cddo_pkg::STATUS_W-1:0]     rsp_status
);

   cddo_pkg::state_type state_ff, state_in;

   logic [cddo_pkg::YEAR_W-1:0]        yin_ff, yin_in;
   logic [cddo_pkg::MONTH_W-1:0]       min_ff, min_in;
   logic [cddo_pkg::DAY_W-1:0]         din_ff, din_in;
   logic signed [cddo_pkg::OFFS_W-1:0] off_ff, off_in;
   logic signed [cddo_pkg::YWORK_W-1:0] y_ff, y_in;
   logic [cddo_pkg::MONTH_W-1:0]       m_ff, m_in;
   logic signed [cddo_pkg::DWORK_W-1:0] d_ff, d_in;
   logic [cddo_pkg::YEAR_W-1:0]        ymod_ff, ymod_in;
   logic [2:0]                         cnt_ff, cnt_in;
   logic                               done_ff, done_in;
   logic [cddo_pkg::YEAR_W-1:0]        oyear_ff, oyear_in;
   logic [cddo_pkg::MONTH_W-1:0]       omonth_ff, omonth_in;
   logic [cddo_pkg::DAY_W-1:0]         oday_ff, oday_in;
   logic [cddo_pkg::STATUS_W-1:0]      ostat_ff, ostat_in;

   logic [cddo_pkg::YMOD_W-1:0]  ymod_cur, ymod_inc, ymod_dec;
   logic [cddo_pkg::DAY_W-1:0]   mlen_cur, mlen_dec;
   logic [cddo_pkg::MONTH_W-1:0] m_inc, m_dec;
   logic                         wrap_fwd, wrap_back;
   logic [cddo_pkg::YEAR_W-1:0]  reduce_step;
   logic                         go_fwd, go_back;
   logic signed [cddo_pkg::DWORK_W-1:0] addend, d_sum, d_start;
   logic                         date_ok, year_ok;

   // current and neighbouring months for the walk
   assign ymod_cur  = ymod_ff[cddo_pkg::YMOD_W-1:0];
   assign wrap_fwd  = (m_ff == 4'd12);
   assign wrap_back = (m_ff == 4'd1);
   assign m_inc     = wrap_fwd  ? 4'd1  : m_ff + 4'd1;
   assign m_dec     = wrap_back ? 4'd12 : m_ff - 4'd1;
   assign ymod_inc  = (ymod_cur == cddo_pkg::CYCLE_LAST) ? '0 : ymod_cur + 9'd1;
   assign ymod_dec  = (ymod_cur == '0) ? cddo_pkg::CYCLE_LAST : ymod_cur - 9'd1;
   assign mlen_cur  = cddo_pkg::month_len(m_ff, cddo_pkg::is_leap(ymod_cur));
   assign mlen_dec  = cddo_pkg::month_len(m_dec,
                         cddo_pkg::is_leap(wrap_back ? ymod_dec : ymod_cur));

   // walk direction
   assign go_fwd  = d_ff > $signed({{(cddo_pkg::DWORK_W-cddo_pkg::DAY_W){1'b0}}, mlen_cur});
   assign go_back = d_ff[cddo_pkg::DWORK_W-1] || (d_ff == '0);

   // shared day adder
   assign addend = go_fwd
      ? -$signed({{(cddo_pkg::DWORK_W-cddo_pkg::DAY_W){1'b0}}, mlen_cur})
      :  $signed({{(cddo_pkg::DWORK_W-cddo_pkg::DAY_W){1'b0}}, mlen_dec});
   assign d_sum = d_ff + addend;

   // starting day count and input date check
   assign d_start = $signed({{(cddo_pkg::DWORK_W-cddo_pkg::DAY_W){1'b0}}, din_ff})
                  + $signed({off_ff[cddo_pkg::OFFS_W-1], off_ff});
   assign date_ok = (yin_ff != '0) && (yin_ff <= cddo_pkg::YEAR_MAX)
                 && (din_ff != '0) && (din_ff <= mlen_cur);
   assign year_ok = (y_ff >= $signed(15'd1))
                 && (y_ff <= $signed({1'b0, cddo_pkg::YEAR_MAX}));

   assign reduce_step = cddo_pkg::CYCLE_LEN << cnt_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      yin_in    = yin_ff;
      min_in    = min_ff;
      din_in    = din_ff;
      off_in    = off_ff;
      y_in      = y_ff;
      m_in      = m_ff;
      d_in      = d_ff;
      ymod_in   = ymod_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      oyear_in  = oyear_ff;
      omonth_in = omonth_ff;
      oday_in   = oday_ff;
      ostat_in  = ostat_ff;
      case (state_ff)
         cddo_pkg::ST_IDLE: begin
            if (start) begin
               yin_in   = req_in_year;
               min_in   = req_in_month;
               din_in   = req_in_day;
               off_in   = req_day_offset;
               y_in     = $signed({1'b0, req_in_year});
               m_in     = req_in_month;
               ymod_in  = req_in_year;
               cnt_in   = cddo_pkg::REDUCE_TOP;
               state_in = cddo_pkg::ST_REDUCE;
            end
         end
         cddo_pkg::ST_REDUCE: begin
            if (ymod_ff >= reduce_step) begin
               ymod_in = ymod_ff - reduce_step;
            end
            if (cnt_ff == '0) begin
               state_in = cddo_pkg::ST_CHECK;
            end else begin
               cnt_in = cnt_ff - 3'd1;
            end
         end
         cddo_pkg::ST_CHECK: begin
            if (date_ok) begin
               d_in     = d_start;
               state_in = cddo_pkg::ST_WALK;
            end else begin
               oyear_in  = yin_ff;
               omonth_in = min_ff;
               oday_in   = din_ff;
               ostat_in  = cddo_pkg::STATUS_BAD_DATE;
               done_in   = 1'b1;
               state_in  = cddo_pkg::ST_IDLE;
            end
         end
         cddo_pkg::ST_WALK: begin
            if (go_fwd) begin
               d_in = d_sum;
               m_in = m_inc;
               if (wrap_fwd) begin
                  y_in    = y_ff + 15'sd1;
                  ymod_in = {{(cddo_pkg::YEAR_W-cddo_pkg::YMOD_W){1'b0}}, ymod_inc};
               end
            end else if (go_back) begin
               d_in = d_sum;
               m_in = m_dec;
               if (wrap_back) begin
                  y_in    = y_ff - 15'sd1;
                  ymod_in = {{(cddo_pkg::YEAR_W-cddo_pkg::YMOD_W){1'b0}}, ymod_dec};
               end
            end else begin
               if (year_ok) begin
                  oyear_in  = y_ff[cddo_pkg::YEAR_W-1:0];
                  omonth_in = m_ff;
                  oday_in   = d_ff[cddo_pkg::DAY_W-1:0];
                  ostat_in  = cddo_pkg::STATUS_OK;
               end else begin
                  oyear_in  = yin_ff;
                  omonth_in = min_ff;
                  oday_in   = din_ff;
                  ostat_in  = cddo_pkg::STATUS_BAD_YEAR;
               end
               done_in  = 1'b1;
               state_in = cddo_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cddo_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cddo_pkg::ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      yin_ff    <= yin_in;
      min_ff    <= min_in;
      din_ff    <= din_in;
      off_ff    <= off_in;
      y_ff      <= y_in;
      m_ff      <= m_in;
      d_ff      <= d_in;
      ymod_ff   <= ymod_in;
      cnt_ff    <= cnt_in;
      oyear_ff  <= oyear_in;
      omonth_ff <= omonth_in;
      oday_ff   <= oday_in;
      ostat_ff  <= ostat_in;
   end

   assign busy          = (state_ff != cddo_pkg::ST_IDLE);
   assign rsp_done      = done_ff;
   assign rsp_out_year  = oyear_ff;
   assign rsp_out_month = omonth_ff;
   assign rsp_out_day   = oday_ff;
   assign rsp_status    = ostat_ff;

endmodule
